// ===== hdl/brag_pkg.sv =====
// ----------------------------------------------------------------------------
// brag_pkg
// Shared widths, codes and types for the BMP rotate address generator.
// ----------------------------------------------------------------------------
package brag_pkg;

  localparam int BYTE_W     = 8;
  localparam int PIXEL_W    = 24;
  localparam int PARTIAL_W  = 16;
  localparam int OFFSET_W   = 26;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes on the configuration port
  localparam cfg_idx_t REG_SRC_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_SRC_HEIGHT = 2'd1;

  // which byte of a pixel is expected next (blue, green, red)
  typedef enum logic [2:0] {
    PH_BLUE  = 3'b001,
    PH_GREEN = 3'b010,
    PH_RED   = 3'b100
  } phase_t;

endpackage

// ===== hdl/bmp_rotate_address_generator_top.sv =====
// ----------------------------------------------------------------------------
// bmp_rotate_address_generator_top
// Byte stream of a 24-bit bottom-up BMP pixel array in, pixels with their
// byte offset in the 90-degree turned padded array out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / data_byte): one byte of the source
//   pixel array per request, row padding included. Padding bytes and the
//   first two bytes of each pixel give no result.
//   Output channel (out_valid / out_stall): one request per finished pixel
//   with pixel_bgr, dest_offset and frame_last (set on the frame's final
//   pixel; the stream then wraps to the next frame).
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
//   is the source width, 1 the source height. cfg_ready is always high.
//   A write to either register restarts the stream; write only when idle.
//   Dimensions of 0 act as 1, above MAX_DIM act as MAX_DIM.
// Timing:
//   One byte per cycle sustained while in_stall is low. A pixel is
//   registered in the intake stage when its red byte is taken; from there
//   it goes through the stride multiply into the result register.
//   While the receiver stalls, the result register holds; the intake stage
//   still takes bytes until a finished pixel waits there, then in_stall
//   rises combinationally with out_stall.
// Reset: stream position cleared, both dimensions back to 1.
// ----------------------------------------------------------------------------
module bmp_rotate_address_generator_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brag_pkg::CFG_DATA_W-1:0] cfg_data,
  // byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [brag_pkg::BYTE_W-1:0]     data_byte,
  // pixel output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [brag_pkg::PIXEL_W-1:0]    pixel_bgr,
  output logic [brag_pkg::OFFSET_W-1:0]   dest_offset,
  output logic                            frame_last
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM+1);

  logic [brag_pkg::CFG_DATA_W-1:0] src_width;
  logic [brag_pkg::CFG_DATA_W-1:0] src_height;

  logic          cfg_write;
  logic          restart;
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;

  logic                         s1_valid;
  logic                         s1_take;
  logic [brag_pkg::PIXEL_W-1:0] s1_pixel;
  logic [CW-1:0]                s1_dest_row;
  logic [CW-1:0]                s1_row;
  logic                         s1_last;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  // only the two known registers restart the stream
  assign restart   = cfg_write &&
                     (cfg_index == brag_pkg::REG_SRC_WIDTH ||
                      cfg_index == brag_pkg::REG_SRC_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= brag_pkg::CFG_DATA_W'(1);
      src_height <= brag_pkg::CFG_DATA_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        brag_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        brag_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the dimensions to 1..MAX_DIM
  always_comb begin
    if (src_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(src_width) > 32'(MAX_DIM)) begin
      w_eff = DW'(MAX_DIM);
    end else begin
      w_eff = DW'(src_width);
    end
  end

  always_comb begin
    if (src_height == '0) begin
      h_eff = DW'(1);
    end else if (32'(src_height) > 32'(MAX_DIM)) begin
      h_eff = DW'(MAX_DIM);
    end else begin
      h_eff = DW'(src_height);
    end
  end

  brag_unpack #(
    .MAX_DIM (MAX_DIM)
  ) u_unpack (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .s1_take     (s1_take),
    .s1_valid    (s1_valid),
    .s1_pixel    (s1_pixel),
    .s1_dest_row (s1_dest_row),
    .s1_row      (s1_row),
    .s1_last     (s1_last)
  );

  brag_addr #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .h_eff       (h_eff),
    .s1_valid    (s1_valid),
    .s1_pixel    (s1_pixel),
    .s1_dest_row (s1_dest_row),
    .s1_row      (s1_row),
    .s1_last     (s1_last),
    .s1_take     (s1_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_bgr   (pixel_bgr),
    .dest_offset (dest_offset),
    .frame_last  (frame_last)
  );

endmodule

// ===== hdl/brag_unpack.sv =====
// ----------------------------------------------------------------------------
// brag_unpack
// Byte intake: drops row padding, assembles BGR pixels and tracks the
// source position. Holds one finished pixel for the address stage.
// ----------------------------------------------------------------------------
module brag_unpack #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [$clog2(MAX_DIM+1)-1:0]  w_eff,
  input  logic [$clog2(MAX_DIM+1)-1:0]  h_eff,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brag_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          s1_take,
  output logic                          s1_valid,
  output logic [brag_pkg::PIXEL_W-1:0]  s1_pixel,
  output logic [$clog2(MAX_DIM)-1:0]    s1_dest_row,
  output logic [$clog2(MAX_DIM)-1:0]    s1_row,
  output logic                          s1_last
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM+1);

  brag_pkg::phase_t                     byte_phase;
  logic [brag_pkg::PARTIAL_W-1:0]       partial_pixel;
  logic [CW-1:0]                        column_count;
  logic [CW-1:0]                        row_count;
  logic [1:0]                           pad_remaining;

  logic          accept;
  logic          emit;
  logic [DW:0]   col_inc;
  logic [DW:0]   row_inc;
  logic          col_wrap;
  logic          row_wrap;
  logic [CW-1:0] dest_row;

  assign in_stall = s1_valid && !s1_take;
  assign accept   = in_valid && !in_stall;
  assign emit     = accept && (pad_remaining == 2'd0) && (byte_phase == brag_pkg::PH_RED);

  assign col_inc  = (DW+1)'(column_count) + (DW+1)'(1);
  assign row_inc  = (DW+1)'(row_count) + (DW+1)'(1);
  assign col_wrap = col_inc >= {1'b0, w_eff};
  assign row_wrap = row_inc >= {1'b0, h_eff};
  assign dest_row = CW'(w_eff - DW'(1) - DW'(column_count));

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      byte_phase    <= brag_pkg::PH_BLUE;
      partial_pixel <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= 2'd0;
    end else if (accept) begin
      if (pad_remaining != 2'd0) begin
        pad_remaining <= pad_remaining - 2'd1;
      end else begin
        case (byte_phase)
          brag_pkg::PH_BLUE: begin
            partial_pixel <= {8'h00, data_byte};
            byte_phase    <= brag_pkg::PH_GREEN;
          end
          brag_pkg::PH_GREEN: begin
            partial_pixel[15:8] <= data_byte;
            byte_phase          <= brag_pkg::PH_RED;
          end
          brag_pkg::PH_RED: begin
            partial_pixel <= '0;
            byte_phase    <= brag_pkg::PH_BLUE;
            if (col_wrap) begin
              column_count  <= '0;
              // row padding of a 24-bit row is width mod 4
              pad_remaining <= w_eff[1:0];
              if (row_wrap) begin
                row_count <= '0;
              end else begin
                row_count <= row_count + CW'(1);
              end
            end else begin
              column_count <= column_count + CW'(1);
            end
          end
          default: begin
            byte_phase <= brag_pkg::PH_BLUE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_valid <= 1'b0;
    end else if (emit) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_pixel    <= {data_byte, partial_pixel};
      s1_dest_row <= dest_row;
      s1_row      <= row_count;
      s1_last     <= col_wrap && row_wrap;
    end
  end

endmodule

// ===== hdl/brag_addr.sv =====
// ----------------------------------------------------------------------------
// brag_addr
// Destination offset: row * stride + 3 * column of the turned image,
// registered into the result stage.
// ----------------------------------------------------------------------------
module brag_addr #(
  parameter int MAX_DIM = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(MAX_DIM+1)-1:0]  h_eff,
  input  logic                          s1_valid,
  input  logic [brag_pkg::PIXEL_W-1:0]  s1_pixel,
  input  logic [$clog2(MAX_DIM)-1:0]    s1_dest_row,
  input  logic [$clog2(MAX_DIM)-1:0]    s1_row,
  input  logic                          s1_last,
  output logic                          s1_take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [brag_pkg::PIXEL_W-1:0]  pixel_bgr,
  output logic [brag_pkg::OFFSET_W-1:0] dest_offset,
  output logic                          frame_last
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM+1);
  localparam int SW = DW + 2;
  localparam int PW = CW + SW;
  localparam int OW = PW + 1;

  logic [SW-1:0] stride;
  logic [PW-1:0] prod;
  logic [OW-1:0] offset;

  // destination row stride: 3*h plus padding, and the padding is h mod 4
  always_ff @(posedge clk) begin
    stride <= SW'({h_eff, 1'b0}) + SW'(h_eff) + SW'(h_eff[1:0]);
  end

  assign prod    = PW'(s1_dest_row) * PW'(stride);
  assign offset  = OW'(prod) + OW'({s1_row, 1'b0}) + OW'(s1_row);
  assign s1_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_valid) begin
      pixel_bgr   <= s1_pixel;
      dest_offset <= brag_pkg::OFFSET_W'(offset);
      frame_last  <= s1_last;
    end
  end

endmodule

// ===== tb/bmp_rotate_address_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// bmp_rotate_address_generator_top_tb
// Self-checking bench for the BMP rotate address generator. A directed table
// covers reset defaults, clamped and extreme dimensions, padding drop, frame
// wrap and restart on a register write. Randomly sized frames follow, with
// random bytes, random idling on both channels, a long receiver hold and a
// sender pause. Each request is checked against the predictor or a typed row.
// ----------------------------------------------------------------------------
module bmp_rotate_address_generator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM      = 4096;
  localparam int PIXEL_BYTES  = 3;
  localparam int ROW_ALIGN    = 4;
  localparam int RANDOM_BYTES = 1500;
  localparam int LONG_HOLD    = 64;      // receiver hold-off, in cycles
  localparam int SETTLE       = 4;       // pipeline is two deep; a little spare
  localparam int CYCLE_LIMIT  = 200000;

  // indexes that map to no register; a write there must leave the stream alone
  localparam brag_pkg::cfg_idx_t REG_UNMAPPED_LO = 2'd2;
  localparam brag_pkg::cfg_idx_t REG_UNMAPPED_HI = 2'd3;

  // one pixel request as seen on the output channel
  typedef struct packed {
    logic [brag_pkg::PIXEL_W-1:0]  pixel;
    logic [brag_pkg::OFFSET_W-1:0] offset;
    logic                          last;
  } pixel_req_t;

  // directed table: a register write, a plain byte (predicted), or a byte
  // that finishes a pixel whose request is written out by hand
  typedef enum logic [1:0] {
    ST_WRITE,
    ST_BYTE,
    ST_PIXEL
  } step_kind_t;

  typedef struct packed {
    step_kind_t                      kind;
    brag_pkg::cfg_idx_t              index;   // only meaningful on ST_WRITE rows
    logic [brag_pkg::CFG_DATA_W-1:0] value;   // register data, or the byte in [7:0]
    pixel_req_t                      want;
  } step_t;

  localparam int DIRECTED_LEN = 29;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  brag_pkg::cfg_idx_t              cfg_index;
  logic [brag_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [brag_pkg::BYTE_W-1:0]     data_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic [brag_pkg::PIXEL_W-1:0]    pixel_bgr;
  logic [brag_pkg::OFFSET_W-1:0]   dest_offset;
  logic                            frame_last;

  // pixel requests still owed by the block, oldest first
  pixel_req_t rotated_pixels_due[$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_fed      = 0;
  int unsigned cycle_count    = 0;

  // pacing controls shared between the sender and receiver processes
  bit steady        = 1'b0;  // no idling on either side
  bit long_hold_req = 1'b0;  // receiver to take one long hold-off next

  // predictor state
  logic [brag_pkg::CFG_DATA_W-1:0] width_reg;
  logic [brag_pkg::CFG_DATA_W-1:0] height_reg;
  brag_pkg::phase_t                next_phase;
  logic [brag_pkg::PARTIAL_W-1:0]  partial;
  logic [11:0]                     col;
  logic [11:0]                     row;
  logic [1:0]                      pad_left;

  // Directed stimulus. Typed requests are the ones that follow at a glance:
  // 1x1 defaults (stride 4, every pixel ends the frame), clamped width with
  // full height (stride 12288, first pixel at 0), full width with height 1
  // (first pixel on the last destination row) and the restart mid-pixel.
  step_t directed_steps [DIRECTED_LEN] = '{
    // reset: 1x1, one padding byte after each pixel
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h000, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h000, '0},
    '{ST_PIXEL, brag_pkg::REG_SRC_WIDTH,  13'h000, '{24'h000000, 26'd0, 1'b1}},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h0FF, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h0FF, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h0FF, '0},
    '{ST_PIXEL, brag_pkg::REG_SRC_WIDTH,  13'h0FF, '{24'hFFFFFF, 26'd0, 1'b1}},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h05A, '0},
    // width 0 acts as 1, height all ones acts as MAX_DIM
    '{ST_WRITE, brag_pkg::REG_SRC_WIDTH,  13'h0000, '0},
    '{ST_WRITE, brag_pkg::REG_SRC_HEIGHT, 13'h1FFF, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h011, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h022, '0},
    '{ST_PIXEL, brag_pkg::REG_SRC_WIDTH,  13'h033, '{24'h332211, 26'd0, 1'b0}},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h080, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h001, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h002, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h003, '0},
    // widest row, single row
    '{ST_WRITE, brag_pkg::REG_SRC_WIDTH,  13'd4096, '0},
    '{ST_WRITE, brag_pkg::REG_SRC_HEIGHT, 13'd1,    '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h044, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h055, '0},
    '{ST_PIXEL, brag_pkg::REG_SRC_WIDTH,  13'h066, '{24'h665544, 26'd16380, 1'b0}},
    // two bytes of a pixel held, then a write throws them away
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h0AB, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h0CD, '0},
    '{ST_WRITE, brag_pkg::REG_SRC_WIDTH,  13'd2,    '0},
    '{ST_WRITE, brag_pkg::REG_SRC_HEIGHT, 13'd1,    '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h001, '0},
    '{ST_BYTE,  brag_pkg::REG_SRC_WIDTH,  13'h002, '0},
    '{ST_PIXEL, brag_pkg::REG_SRC_WIDTH,  13'h003, '{24'h030201, 26'd4, 1'b0}}
  };

  bmp_rotate_address_generator_top #(
    .MAX_DIM (MAX_DIM)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_bgr   (pixel_bgr),
    .dest_offset (dest_offset),
    .frame_last  (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic int unsigned clamp_dim(input logic [brag_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // padding bytes that bring a row of n pixels to a multiple of four
  function automatic int unsigned row_pad(input int unsigned n);
    return (ROW_ALIGN - (PIXEL_BYTES * n) % ROW_ALIGN) % ROW_ALIGN;
  endfunction

  function automatic void restart_position();
    next_phase = brag_pkg::PH_BLUE;
    partial    = '0;
    col        = '0;
    row        = '0;
    pad_left   = '0;
  endfunction

  // Takes one accepted byte; returns 1 with the rotated pixel when the byte
  // finishes a pixel.
  function automatic bit next_rotated_pixel(input logic [brag_pkg::BYTE_W-1:0] b,
                                            output pixel_req_t res);
    int unsigned     w;
    int unsigned     h;
    longint unsigned stride;
    longint unsigned ofs;
    res = '0;
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    // padding after a row is swallowed before anything else
    if (pad_left != 0) begin
      pad_left = pad_left - 2'd1;
      return 1'b0;
    end
    case (next_phase)
      brag_pkg::PH_BLUE: begin
        partial    = {8'h00, b};
        next_phase = brag_pkg::PH_GREEN;
        return 1'b0;
      end
      brag_pkg::PH_GREEN: begin
        partial[15:8] = b;
        next_phase    = brag_pkg::PH_RED;
        return 1'b0;
      end
      default: ;
    endcase
    res.pixel  = {b, partial};
    next_phase = brag_pkg::PH_BLUE;
    partial    = '0;
    // turned image is h pixels wide; source column c lands on row w-1-c
    stride     = longint'(PIXEL_BYTES) * h + row_pad(h);
    ofs        = longint'(w - 1 - col) * stride + longint'(PIXEL_BYTES) * row;
    res.offset = brag_pkg::OFFSET_W'(ofs);
    if (col + 1 >= w) begin
      col      = '0;
      pad_left = 2'(row_pad(w));
      if (row + 1 >= h) begin
        row      = '0;
        res.last = 1'b1;
      end else begin
        row = row + 12'd1;
      end
    end else begin
      col = col + 12'd1;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one byte, wait for the request to go through, then idle a while.
  // A typed row replaces the predicted request with the hand-written one.
  task automatic feed_byte(input logic [brag_pkg::BYTE_W-1:0] b, input bit typed,
                           input pixel_req_t want);
    pixel_req_t res;
    bit         got;
    int         gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = next_rotated_pixel(b, res);
    if (typed) rotated_pixels_due.push_back(want);
    else if (got) rotated_pixels_due.push_back(res);
    bytes_fed++;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed pixel come out, plus the pipeline depth
  // for bytes still in flight that give no result.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (rotated_pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input brag_pkg::cfg_idx_t idx,
                           input logic [brag_pkg::CFG_DATA_W-1:0] val);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    // only the two mapped registers restart the stream
    if (idx == brag_pkg::REG_SRC_WIDTH) begin
      width_reg = val;
      restart_position();
    end else if (idx == brag_pkg::REG_SRC_HEIGHT) begin
      height_reg = val;
      restart_position();
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly small frames so they complete often; now and then a medium size,
  // an edge value or any 13-bit value
  function automatic logic [brag_pkg::CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      7: begin
        case ($urandom_range(0, 5))
          0:       return 13'd0;
          1:       return 13'd1;
          2:       return 13'd4095;
          3:       return 13'd4096;
          4:       return 13'd4097;
          default: return 13'h1FFF;
        endcase
      end
      8:       return brag_pkg::CFG_DATA_W'($urandom_range(0, 8191));
      9:       return brag_pkg::CFG_DATA_W'($urandom_range(10, 40));
      default: return brag_pkg::CFG_DATA_W'($urandom_range(1, 9));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random hold-off before each request, with an occasional
  // long hold so the intake fills and in_stall rises.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (rst || out_valid !== 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Output check: every request that goes through is matched against the
  // oldest owed pixel, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_check
    pixel_req_t want;
    if (!rst && out_stall === 1'b0 && out_valid !== 1'b0) begin
      if (rotated_pixels_due.size() == 0) begin
        $display("%0t: unexpected pixel request: pixel %h offset %h last %b",
                 $time, pixel_bgr, dest_offset, frame_last);
        mismatch_count++;
      end else begin
        want = rotated_pixels_due.pop_front();
        if (out_valid !== 1'b1) begin
          $display("%0t: out_valid expected 1 got %b", $time, out_valid);
          mismatch_count++;
        end
        if (pixel_bgr !== want.pixel) begin
          $display("%0t: pixel_bgr expected %h got %h", $time, want.pixel, pixel_bgr);
          mismatch_count++;
        end
        if (dest_offset !== want.offset) begin
          $display("%0t: dest_offset expected %0d got %0d",
                   $time, want.offset, dest_offset);
          mismatch_count++;
        end
        if (frame_last !== want.last) begin
          $display("%0t: frame_last expected %b got %b", $time, want.last, frame_last);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bmp_rotate_address_generator_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                              phase_no;
    int                              phase_len;
    logic [brag_pkg::CFG_DATA_W-1:0] new_w;
    logic [brag_pkg::CFG_DATA_W-1:0] new_h;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= brag_pkg::REG_SRC_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    data_byte <= '0;
    width_reg  = 13'd1;
    height_reg = 13'd1;
    restart_position();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      case (directed_steps[i].kind)
        ST_WRITE: write_reg(directed_steps[i].index, directed_steps[i].value);
        ST_PIXEL: feed_byte(directed_steps[i].value[7:0], 1'b1, directed_steps[i].want);
        default:  feed_byte(directed_steps[i].value[7:0], 1'b0, '0);
      endcase
    end

    // random frames; each phase sets new dimensions and may stop mid-frame,
    // so the next write also restarts a stream in progress
    phase_no = 0;
    while (bytes_fed < DIRECTED_LEN + RANDOM_BYTES) begin
      new_w = pick_dim();
      new_h = pick_dim();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(brag_pkg::REG_SRC_WIDTH, new_w);
        write_reg(brag_pkg::REG_SRC_HEIGHT, new_h);
      end else begin
        write_reg(brag_pkg::REG_SRC_HEIGHT, new_h);
        write_reg(brag_pkg::REG_SRC_WIDTH, new_w);
      end
      // every fourth phase runs flat out on both sides
      steady = (phase_no % 4 == 2);
      if (phase_no == 1 || $urandom_range(0, 5) == 0) long_hold_req = 1'b1;
      phase_len = $urandom_range(40, 200);
      for (int k = 0; k < phase_len; k++) begin
        if (k == phase_len / 2) begin
          // sender waits for every owed pixel before going on
          if (phase_no == 3 || $urandom_range(0, 4) == 0) settle_idle();
          // write to an unmapped index: position must carry on untouched
          if ($urandom_range(0, 5) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                      brag_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
        end
        feed_byte(brag_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
      end
      phase_no++;
    end

    settle_idle();
    repeat (2 * SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("bmp_rotate_address_generator_top test passed");
    end else begin
      $display("bmp_rotate_address_generator_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/brag_pkg.sv
hdl/brag_unpack.sv
hdl/brag_addr.sv
hdl/bmp_rotate_address_generator_top.sv
tb/bmp_rotate_address_generator_top_tb.sv
